// ===== src/i2cm_pkg.sv =====
`default_nettype none

package i2cm_pkg;

    // command codes of the input word
    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4,
        CMD_PROBE = 3'd5
    } cmd_t;

    // bus sequencer phases, one-hot
    typedef enum logic [17:0] {
        PH_IDLE = 18'b000000000000000001,
        PH_ST0  = 18'b000000000000000010,
        PH_ST1  = 18'b000000000000000100,
        PH_ST2  = 18'b000000000000001000,
        PH_SP0  = 18'b000000000000010000,
        PH_SP1  = 18'b000000000000100000,
        PH_SP2  = 18'b000000000001000000,
        PH_WD   = 18'b000000000010000000,
        PH_WH   = 18'b000000000100000000,
        PH_WL   = 18'b000000001000000000,
        PH_AR   = 18'b000000010000000000,
        PH_AH   = 18'b000000100000000000,
        PH_AL   = 18'b000001000000000000,
        PH_RH   = 18'b000010000000000000,
        PH_RL   = 18'b000100000000000000,
        PH_KD   = 18'b001000000000000000,
        PH_KH   = 18'b010000000000000000,
        PH_KL   = 18'b100000000000000000
    } phase_t;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam int unsigned MSB_IDX = 7;
    localparam logic [7:0] HALF_PERIOD_RST = 8'd8;

    // sequencer state
    typedef struct packed {
        phase_t      phase;
        logic [2:0]  active_cmd;
        logic [7:0]  tick_count;
        logic [3:0]  bit_count;
        logic [7:0]  shift_reg;
        logic        ack_choice;
        logic        scl_level;
        logic        sda_level;
        logic        sda_enable;
        logic [7:0]  received_byte;
        logic        ack_seen;
        logic        error_flag;
    } seq_state_t;

    localparam seq_state_t SEQ_RST = '{
        phase:         PH_IDLE,
        active_cmd:    3'd0,
        tick_count:    8'd0,
        bit_count:     4'd0,
        shift_reg:     8'd0,
        ack_choice:    1'b0,
        scl_level:     1'b1,
        sda_level:     1'b1,
        sda_enable:    1'b1,
        received_byte: 8'd0,
        ack_seen:      1'b0,
        error_flag:    1'b0
    };

    // pin levels set on entry to a phase
    function automatic seq_state_t enter_phase(seq_state_t s, phase_t p);
        seq_state_t r;
        r            = s;
        r.phase      = p;
        r.tick_count = 8'd1;
        unique case (p)
            PH_ST0:
            begin
                r.sda_enable = 1'b1;
                r.sda_level  = 1'b1;
                r.scl_level  = 1'b1;
            end
            PH_ST1: r.sda_level = 1'b0;
            PH_ST2: r.scl_level = 1'b0;
            PH_SP0:
            begin
                r.sda_enable = 1'b1;
                r.sda_level  = 1'b0;
            end
            PH_SP1: r.scl_level = 1'b1;
            PH_SP2: r.sda_level = 1'b1;
            PH_WD:
            begin
                r.sda_enable = 1'b1;
                r.sda_level  = s.shift_reg[MSB_IDX];
            end
            PH_WH, PH_AH, PH_KH: r.scl_level = 1'b1;
            PH_WL, PH_AL, PH_RL, PH_KL: r.scl_level = 1'b0;
            PH_AR:
            begin
                r.sda_enable = 1'b0;
                r.sda_level  = 1'b1;
            end
            PH_RH:
            begin
                r.sda_enable = 1'b0;
                r.sda_level  = 1'b1;
                r.scl_level  = 1'b1;
            end
            PH_KD:
            begin
                r.sda_enable = 1'b1;
                r.sda_level  = ~s.ack_choice;
            end
            default: r.phase = p;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/i2c_master_byte_engine_core.sv =====
// result word: registered, valid in the cycle after its input word is accepted
// throughput: one input word per cycle; each word is one sequencer tick
// input stalls only while a result word waits with out_ready low
// reset (rst_n low, asynchronous): sequencer idle with lines driven high,
// half_period back to 8, result register empty
`default_nettype none

module i2c_master_byte_engine_core
    import i2cm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  cmd,
    input  wire logic [7:0]  tx_byte,
    input  wire logic        send_ack,
    input  wire logic        sda_in,
    input  wire logic        scl_in,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             scl_out,
    output logic             sda_out,
    output logic             sda_drive,
    output logic             busy_res,
    output logic             done_res,
    output logic [7:0]       rx_byte,
    output logic             ack_bit,
    output logic             bus_error
);

    logic [7:0]  half_period_reg;
    seq_state_t  state_reg;
    seq_state_t  state_next;
    logic        step_done;
    logic        accept;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [14:0] res_reg;
    logic [14:0] res_next;

    // handshake
    assign in_ready = ~out_valid_reg | out_ready;
    assign accept   = in_valid & in_ready;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            half_period_reg <= HALF_PERIOD_RST;
        else if (cfg_we)
            half_period_reg <= cfg_wdata;
    end

    // tick logic
    i2cm_step u_step (
        .cur         (state_reg),
        .half_period (half_period_reg),
        .cmd         (cmd),
        .tx_byte     (tx_byte),
        .send_ack    (send_ack),
        .sda_in      (sda_in),
        .scl_in      (scl_in),
        .nxt         (state_next),
        .done        (step_done)
    );

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= SEQ_RST;
        else if (accept)
            state_reg <= state_next;
    end

    // result word
    assign res_next = {state_next.scl_level, state_next.sda_level, state_next.sda_enable,
                       (state_next.phase != PH_IDLE), step_done, state_next.received_byte,
                       state_next.ack_seen, state_next.error_flag};
    assign out_valid_next = accept | (out_valid_reg & ~out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign scl_out   = res_reg[14];
    assign sda_out   = res_reg[13];
    assign sda_drive = res_reg[12];
    assign busy_res  = res_reg[11];
    assign done_res  = res_reg[10];
    assign rx_byte   = res_reg[9:2];
    assign ack_bit   = res_reg[1];
    assign bus_error = res_reg[0];

    // checks
    a_idle_tick_zero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_IDLE |-> state_reg.tick_count == 8'd0)
        else $error("tick counter running while idle");

    a_bit_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.bit_count <= BITS_PER_BYTE)
        else $error("bit counter past one byte");

    a_released_high: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.sda_enable |-> state_reg.sda_level)
        else $error("released sda not reading high");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg[10] |-> !res_reg[11])
        else $error("done word still marked busy");

endmodule

`default_nettype wire

// ===== src/i2cm_step.sv =====
`default_nettype none

module i2cm_step
    import i2cm_pkg::*;
(
    input  seq_state_t  cur,
    input  logic [7:0]  half_period,
    input  logic [2:0]  cmd,
    input  logic [7:0]  tx_byte,
    input  logic        send_ack,
    input  logic        sda_in,
    input  logic        scl_in,
    output seq_state_t  nxt,
    output logic        done
);

    // one tick of the sequencer
    always_comb
    begin
        seq_state_t s;
        phase_t     nph;
        logic       fin;
        logic [3:0] bc_inc;

        s      = cur;
        nph    = PH_IDLE;
        fin    = 1'b0;
        done   = 1'b0;
        bc_inc = cur.bit_count + 4'd1;

        priority if (cur.phase == PH_IDLE)
        begin
            // command acceptance
            if (cmd == CMD_START || cmd == CMD_STOP || cmd == CMD_WRITE ||
                cmd == CMD_READ || cmd == CMD_PROBE)
            begin
                s.active_cmd = cmd;
                s.error_flag = 1'b0;
                s.bit_count  = 4'd0;
                priority if (cmd == CMD_START)
                    s = enter_phase(s, PH_ST0);
                else if (cmd == CMD_STOP)
                    s = enter_phase(s, PH_SP0);
                else if (cmd == CMD_WRITE)
                begin
                    s.shift_reg = tx_byte;
                    s = enter_phase(s, PH_WD);
                end
                else if (cmd == CMD_READ)
                begin
                    s.shift_reg  = 8'd0;
                    s.ack_choice = send_ack;
                    s = enter_phase(s, PH_RH);
                end
                else if (sda_in && scl_in)
                begin
                    s.shift_reg = tx_byte;
                    s = enter_phase(s, PH_ST0);
                end
                else
                begin
                    s.error_flag = 1'b1;
                    s.ack_seen   = 1'b1;
                    done         = 1'b1;
                end
            end
        end
        else if (cur.tick_count >= half_period)
        begin
            // phase end and transition
            unique case (cur.phase)
                PH_ST0: nph = PH_ST1;
                PH_ST1: nph = PH_ST2;
                PH_ST2:
                begin
                    if (cur.active_cmd == CMD_PROBE)
                    begin
                        s.bit_count = 4'd0;
                        nph = PH_WD;
                    end
                    else
                        fin = 1'b1;
                end
                PH_SP0: nph = PH_SP1;
                PH_SP1: nph = PH_SP2;
                PH_SP2: fin = 1'b1;
                PH_WD:  nph = PH_WH;
                PH_WH:  nph = PH_WL;
                PH_WL:
                begin
                    s.shift_reg = {cur.shift_reg[6:0], 1'b0};
                    s.bit_count = bc_inc;
                    nph = (bc_inc >= BITS_PER_BYTE) ? PH_AR : PH_WD;
                end
                PH_AR: nph = PH_AH;
                PH_AH:
                begin
                    s.ack_seen = sda_in;
                    nph = PH_AL;
                end
                PH_AL:
                begin
                    if (cur.active_cmd == CMD_PROBE)
                        nph = PH_SP0;
                    else
                        fin = 1'b1;
                end
                PH_RH:
                begin
                    s.shift_reg = {cur.shift_reg[6:0], sda_in};
                    s.bit_count = bc_inc;
                    nph = PH_RL;
                end
                PH_RL:
                begin
                    if (cur.bit_count >= BITS_PER_BYTE)
                    begin
                        s.received_byte = cur.shift_reg;
                        nph = PH_KD;
                    end
                    else
                        nph = PH_RH;
                end
                PH_KD: nph = PH_KH;
                PH_KH: nph = PH_KL;
                PH_KL:
                begin
                    s.sda_level = 1'b1;
                    fin = 1'b1;
                end
                default: fin = 1'b1;
            endcase
            if (fin)
            begin
                s.phase      = PH_IDLE;
                s.tick_count = 8'd0;
                done         = 1'b1;
            end
            else
                s = enter_phase(s, nph);
        end
        else
        begin
            // hold current phase
            s.tick_count = cur.tick_count + 8'd1;
        end

        nxt = s;
    end

endmodule

`default_nettype wire
